// ===== hw/rtl/rtcbcd_pkg.sv =====
// Package with the word types, constants and helper functions of the RTC BCD time decoder.
`timescale 1ns / 1ps
package rtcbcd_pkg;

    // Width of one raw BCD register and of the widest decoded intermediate value.
    localparam int unsigned RAW_W  = 8;
    localparam int unsigned YEAR_W = 9;

    // Masks applied to the raw registers before conversion.
    localparam logic [RAW_W-1:0] SEC_MASK     = 8'h7f;
    localparam logic [RAW_W-1:0] MIN_MASK     = 8'h7f;
    localparam logic [RAW_W-1:0] HOUR24_MASK  = 8'h3f;
    localparam logic [RAW_W-1:0] HOUR12_MASK  = 8'h1f;
    localparam logic [RAW_W-1:0] WDAY_MASK    = 8'h03;
    localparam logic [RAW_W-1:0] MDAY_MASK    = 8'h3f;
    localparam logic [RAW_W-1:0] MONTH_MASK   = 8'h1f;
    localparam int unsigned      PM_BIT       = 5;
    localparam int unsigned      CENTURY_BIT  = 7;

    // Range limits of the validity check.
    localparam logic [YEAR_W-1:0] YEAR_MIN    = 9'd70;
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 9'd199;
    localparam logic [YEAR_W-1:0] CENTURY_ADD = 9'd100;
    localparam logic [RAW_W-1:0]  HALF_DAY    = 8'd12;
    localparam logic [RAW_W-1:0]  FULL_DAY    = 8'd24;
    localparam logic [RAW_W-1:0]  SIXTY       = 8'd60;
    localparam logic [RAW_W-1:0]  MONTHS      = 8'd12;
    localparam logic [RAW_W-1:0]  FEBRUARY    = 8'd2;

    // Epoch values used on fallback: Thursday 1970-01-01 00:00:00.
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
    localparam logic [4:0] EPOCH_MDAY    = 5'd1;
    localparam logic [7:0] EPOCH_YEAR    = 8'd70;

    // Reset value of the hour mode register: 12-hour format.
    localparam logic HOUR_MODE_24_RESET = 1'b0;

    typedef struct packed {
        logic [7:0] seconds_byte;
        logic [7:0] minutes_byte;
        logic [7:0] hours_byte;
        logic [7:0] weekday_byte;
        logic [7:0] day_byte;
        logic [7:0] month_byte;
        logic [7:0] year_byte;
    } t_rtc_in_word;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [2:0] weekday;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic       fell_back;
    } t_rtc_out_word;

    // Low digit plus ten times the high digit; digits above nine are summed as they are.
    function automatic logic [RAW_W-1:0] bcd_val(input logic [RAW_W-1:0] b);
        logic [RAW_W-1:0] hi;
        hi = {4'b0000, b[7:4]};
        return {4'b0000, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // Days in a month given as 1..12; February is 28 here, leap years are handled outside.
    function automatic logic [4:0] month_len(input logic [3:0] mon1);
        logic [4:0] len;
        unique case (mon1)
            4'd2:                   len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/rtc_bcd_time_decoder.sv =====
// Top level of the RTC BCD time decoder: input register, decode logic and result register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Word
//  --------  ---------  ------------------------  ------------------------------------
//  in        to block   i_in_valid / o_in_stall   i_in_word  (seven raw BCD registers)
//  out       from block o_out_valid / i_out_stall o_out_word (decoded calendar fields)
//  cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_data (hour_mode_24)
//
// A word is decoded in one pass and a new word can be taken every cycle unless the output
// stalls. It passes the input register, then the result register, with the decode logic
// between them. The reset is synchronous and active low; it empties both stages and puts
// the hour mode into 12-hour format. A stall on the output holds the result register, and
// the input register still takes a word as long as it is free to move or is empty.
module rtc_bcd_time_decoder
    import rtcbcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_in_valid,
    input  t_rtc_in_word  i_in_word,
    output logic          o_in_stall,

    output logic          o_out_valid,
    output t_rtc_out_word o_out_word,
    input  logic          i_out_stall,

    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    output logic          o_cfg_ready
);

    // Hour mode register; the configuration port takes a write in every cycle.
    logic r_hour_mode_24;

    // Input stage.
    logic         r_s1_valid;
    t_rtc_in_word r_s1_word;

    // Result stage.
    logic          r_out_valid;
    t_rtc_out_word r_out_word;
    t_rtc_out_word n_out_word;

    // Each stage moves when the one after it is free or about to be emptied.
    logic out_adv;
    logic s1_adv;

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign s1_adv      = !r_s1_valid || out_adv;
    assign o_in_stall  = !s1_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_mode_24 <= HOUR_MODE_24_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hour_mode_24 <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    // Decode of the word in the input register.
    logic [RAW_W-1:0]  sec;
    logic [RAW_W-1:0]  min;
    logic [RAW_W-1:0]  wday;
    logic [RAW_W-1:0]  mday;
    logic [RAW_W-1:0]  mon1;
    logic [RAW_W-1:0]  hour24;
    logic [RAW_W-1:0]  hour12_raw;
    logic [RAW_W-1:0]  hour12_mod;
    logic [RAW_W-1:0]  hour12;
    logic [RAW_W-1:0]  hour;
    logic [YEAR_W-1:0] year;
    logic              year_ok;
    logic              mon_ok;
    logic              leap_year;
    logic [4:0]        day_lim;
    logic              mday_ok;
    logic              time_ok;
    logic              all_ok;

    always_comb begin
        sec        = bcd_val(r_s1_word.seconds_byte & SEC_MASK);
        min        = bcd_val(r_s1_word.minutes_byte & MIN_MASK);
        wday       = bcd_val(r_s1_word.weekday_byte & WDAY_MASK);
        mday       = bcd_val(r_s1_word.day_byte & MDAY_MASK);
        mon1       = bcd_val(r_s1_word.month_byte & MONTH_MASK);
        hour24     = bcd_val(r_s1_word.hours_byte & HOUR24_MASK);

        // The masked 12-hour value is at most 25, so the remainder needs two compares.
        hour12_raw = bcd_val(r_s1_word.hours_byte & HOUR12_MASK);
        if (hour12_raw >= FULL_DAY) begin
            hour12_mod = hour12_raw - FULL_DAY;
        end else if (hour12_raw >= HALF_DAY) begin
            hour12_mod = hour12_raw - HALF_DAY;
        end else begin
            hour12_mod = hour12_raw;
        end
        hour12 = r_s1_word.hours_byte[PM_BIT] ? hour12_mod + HALF_DAY : hour12_mod;
        hour   = r_hour_mode_24 ? hour24 : hour12;

        year = {1'b0, bcd_val(r_s1_word.year_byte)}
             + (r_s1_word.month_byte[CENTURY_BIT] ? CENTURY_ADD : '0);

        year_ok = (year >= YEAR_MIN) && (year <= YEAR_MAX);
        mon_ok  = (mon1 >= 8'd1) && (mon1 <= MONTHS);

        // Within 1970..2099 the only century year is 2000, which is a leap year, so a year
        // divisible by four is a leap year here.
        leap_year = (year[1:0] == 2'b00);
        day_lim   = month_len(mon1[3:0]);
        if ((mon1 == FEBRUARY) && leap_year) begin
            day_lim = 5'd29;
        end
        mday_ok = (mday >= 8'd1) && (mday <= {3'b000, day_lim});

        time_ok = (hour < FULL_DAY) && (min < SIXTY) && (sec < SIXTY);
        all_ok  = year_ok && mon_ok && mday_ok && time_ok;

        if (all_ok) begin
            n_out_word.seconds          = sec[5:0];
            n_out_word.minutes          = min[5:0];
            n_out_word.hours            = hour[4:0];
            n_out_word.weekday          = wday[2:0];
            n_out_word.day_of_month     = mday[4:0];
            n_out_word.month_index      = 4'(mon1 - 8'd1);
            n_out_word.years_since_1900 = year[7:0];
            n_out_word.fell_back        = 1'b0;
        end else begin
            n_out_word.seconds          = '0;
            n_out_word.minutes          = '0;
            n_out_word.hours            = '0;
            n_out_word.weekday          = EPOCH_WEEKDAY;
            n_out_word.day_of_month     = EPOCH_MDAY;
            n_out_word.month_index      = '0;
            n_out_word.years_since_1900 = EPOCH_YEAR;
            n_out_word.fell_back        = 1'b1;
        end
    end

    // A fallback result carries exactly the epoch.
    a_fallback_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.fell_back) |->
            (r_out_word.seconds == '0) && (r_out_word.minutes == '0) &&
            (r_out_word.hours == '0) && (r_out_word.weekday == EPOCH_WEEKDAY) &&
            (r_out_word.day_of_month == EPOCH_MDAY) && (r_out_word.month_index == '0) &&
            (r_out_word.years_since_1900 == EPOCH_YEAR))
        else $error("fallback result is not the epoch");

    // A decoded result is always inside the calendar ranges.
    a_decoded_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.fell_back) |->
            (r_out_word.seconds < 6'd60) && (r_out_word.minutes < 6'd60) &&
            (r_out_word.hours < 5'd24) && (r_out_word.month_index < 4'd12) &&
            (r_out_word.day_of_month != 5'd0) &&
            (r_out_word.years_since_1900 >= 8'd70) &&
            (r_out_word.years_since_1900 <= 8'd199))
        else $error("decoded result out of range");

    // The input side is stalled only while both the input register and the result register hold a word.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // A word that leaves the input register shows up in the result register next cycle.
    a_word_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_adv) |=> r_out_valid)
        else $error("word lost between stages");

endmodule
